/* rtl/core/password_door_lock_controller_assert.svh */
// ----------------------------------------------------------------------------
// Password door lock controller: assertion macros
// Clocked assertion helpers used by the result queue of the lock controller.
// ----------------------------------------------------------------------------
`ifndef PASSWORD_DOOR_LOCK_CONTROLLER_ASSERT_SVH
`define PASSWORD_DOOR_LOCK_CONTROLLER_ASSERT_SVH

// Property checked on every rising edge of clk outside reset.
`define PDLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define PDLC_ASSERT_NEVER(label, cond, msg) \
  `PDLC_ASSERT(label, !(cond), msg)

`endif

/* rtl/core/pdlc_pkg.sv */
// ----------------------------------------------------------------------------
// Password door lock controller package
// Shared constants, register indexes and result types of the lock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdlc_pkg;

  // Length of one code entry in bytes.
  localparam int CODE_LENGTH = 5;
  localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  // Link byte codes.
  localparam logic [7:0] RDY_IN     = 8'h10;
  localparam logic [7:0] RDY_OUT    = 8'h20;
  localparam logic [7:0] UNMATCHED  = 8'h50;
  localparam logic [7:0] MATCHED    = 8'h05;
  localparam logic [7:0] DELIV1     = 8'h80;
  localparam logic [7:0] DELIV2     = 8'h08;
  localparam logic [7:0] CMD_OPEN   = 8'd43;
  localparam logic [7:0] CMD_CHANGE = 8'd45;
  localparam logic [7:0] WARN       = 8'h3C;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_UNLOCK_TICKS = 3'd0,
    CFG_HOLD_TICKS   = 3'd1,
    CFG_LOCK_TICKS   = 3'd2,
    CFG_ALARM_TICKS  = 3'd3,
    CFG_MAX_TRIALS   = 3'd4
  } cfg_reg_t;

  // Motor drive codes.
  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_CW   = 2'd1;
  localparam logic [1:0] MOTOR_ACW  = 2'd2;

  // Result queue depth; an item can add up to two results.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One result item.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] motor_dir;
    logic       alarm_active;
    logic       last;
  } pdlc_result_t;

  // Results produced by one accepted item.
  typedef struct packed {
    logic [1:0]   count;
    pdlc_result_t first;
    pdlc_result_t second;
  } pdlc_push_t;

endpackage

`default_nettype wire

/* rtl/core/pdlc_in_if.sv */
// ----------------------------------------------------------------------------
// Lock controller input channel
// Valid/ready channel carrying one received byte or one timer tick per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdlc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/pdlc_out_if.sv */
// ----------------------------------------------------------------------------
// Lock controller result channel
// Valid/ready channel carrying one reply and actuator status per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdlc_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [1:0] motor_dir;
  logic       alarm_active;
  logic       last;

  modport source (output valid, output tx_valid, output tx_byte, output motor_dir,
                  output alarm_active, output last, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input motor_dir,
                  input alarm_active, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/pdlc_fsm.sv */
// ----------------------------------------------------------------------------
// Lock controller sequencer
// Setup, command, code check, motor and alarm phases; one item per cycle while accept is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlc_fsm (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pdlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pdlc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                           accept,
  input  wire logic                           func,
  input  wire logic [7:0]                     rx_byte,
  output pdlc_pkg::pdlc_push_t                push
);
  import pdlc_pkg::*;

  typedef enum logic [3:0] {
    M_BOOT, M_SETUP_RDY, M_FIRST, M_SECOND, M_CMD,
    M_OPEN_WAIT, M_OPEN_CODE, M_CHG_WAIT, M_CHG_CODE,
    M_UNLOCK, M_HOLD, M_LOCK, M_SETTLE, M_ALARM
  } mode_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LENGTH - 1);

  logic [7:0] unlock_ticks, hold_ticks, lock_ticks, alarm_ticks;
  logic [2:0] max_trials;

  mode_t            mode, mode_next;
  logic [7:0]       stored_code [CODE_LENGTH];
  logic [7:0]       first_entry [CODE_LENGTH];
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic             mismatch_seen, mismatch_seen_next;
  logic [2:0]       trial_count, trial_count_next;
  logic [7:0]       tick_count, tick_count_next;

  logic [7:0] tick_sum, tick_limit, tick_eff;
  logic       tick_hit, timed, code_last;
  logic [2:0] trials_eff, trial_inc;
  logic       miss_stored, miss_first;
  logic [1:0] ntx;
  logic [7:0] tx0, tx1;
  logic       wr_first, copy_code;
  logic [1:0] motor_next;
  logic       buzz_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_ticks <= 8'd15;
      hold_ticks   <= 8'd3;
      lock_ticks   <= 8'd15;
      alarm_ticks  <= 8'd60;
      max_trials   <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNLOCK_TICKS: unlock_ticks <= cfg_data;
        CFG_HOLD_TICKS:   hold_ticks   <= cfg_data;
        CFG_LOCK_TICKS:   lock_ticks   <= cfg_data;
        CFG_ALARM_TICKS:  alarm_ticks  <= cfg_data;
        CFG_MAX_TRIALS:   max_trials   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Tick counting for the timed phases; a zero limit acts as one.
  always_comb begin
    case (mode)
      M_UNLOCK: tick_limit = unlock_ticks;
      M_HOLD:   tick_limit = hold_ticks;
      M_LOCK:   tick_limit = lock_ticks;
      default:  tick_limit = alarm_ticks;
    endcase
  end
  assign timed    = (mode == M_UNLOCK) || (mode == M_HOLD) || (mode == M_LOCK) ||
                    (mode == M_ALARM);
  assign tick_sum = tick_count + 8'd1;
  assign tick_eff = (tick_limit == 8'd0) ? 8'd1 : tick_limit;
  assign tick_hit = tick_sum >= tick_eff;

  // Code byte compares and trial limit.
  assign code_last   = byte_index == LAST_IDX;
  assign miss_first  = first_entry[byte_index] != rx_byte;
  assign miss_stored = stored_code[byte_index] != rx_byte;
  assign trials_eff  = (max_trials == 3'd0) ? 3'd1 : max_trials;
  assign trial_inc   = trial_count + 3'd1;

  // Next state and replies for the item at the input.
  always_comb begin
    mode_next          = mode;
    byte_index_next    = byte_index;
    mismatch_seen_next = mismatch_seen;
    trial_count_next   = trial_count;
    tick_count_next    = tick_count;
    ntx                = 2'd0;
    tx0                = 8'd0;
    tx1                = 8'd0;
    wr_first           = 1'b0;
    copy_code          = 1'b0;
    if (func) begin
      if (timed) begin
        tick_count_next = tick_hit ? 8'd0 : tick_sum;
        if (tick_hit) begin
          case (mode)
            M_UNLOCK: mode_next = M_HOLD;
            M_HOLD:   mode_next = M_LOCK;
            M_LOCK:   mode_next = M_SETTLE;
            default:  mode_next = M_CMD;
          endcase
        end
      end else if (mode == M_SETTLE) begin
        tick_count_next = 8'd0;
        mode_next       = M_CMD;
      end
    end else begin
      case (mode)
        M_BOOT: begin
          if (rx_byte == RDY_IN) mode_next = M_SETUP_RDY;
        end
        M_SETUP_RDY: begin
          if (rx_byte == RDY_IN) begin
            ntx             = 2'd1;
            tx0             = RDY_OUT;
            byte_index_next = '0;
            mode_next       = M_FIRST;
          end
        end
        M_FIRST: begin
          wr_first        = 1'b1;
          byte_index_next = byte_index + 1'b1;
          if (code_last) begin
            ntx                = 2'd1;
            tx0                = DELIV1;
            byte_index_next    = '0;
            mismatch_seen_next = 1'b0;
            mode_next          = M_SECOND;
          end
        end
        M_SECOND: begin
          mismatch_seen_next = mismatch_seen | miss_first;
          byte_index_next    = byte_index + 1'b1;
          if (code_last) begin
            byte_index_next    = '0;
            ntx                = 2'd2;
            tx0                = DELIV2;
            mismatch_seen_next = 1'b0;
            if (mismatch_seen | miss_first) begin
              tx1       = UNMATCHED;
              mode_next = M_SETUP_RDY;
            end else begin
              tx1       = MATCHED;
              copy_code = 1'b1;
              mode_next = M_CMD;
            end
          end
        end
        M_CMD: begin
          if (rx_byte == CMD_OPEN) begin
            trial_count_next = 3'd0;
            mode_next        = M_OPEN_WAIT;
          end else if (rx_byte == CMD_CHANGE) begin
            trial_count_next = 3'd0;
            mode_next        = M_CHG_WAIT;
          end
        end
        M_OPEN_WAIT, M_CHG_WAIT: begin
          if (rx_byte == ((mode == M_OPEN_WAIT) ? CMD_OPEN : CMD_CHANGE)) begin
            ntx                = 2'd1;
            tx0                = RDY_OUT;
            byte_index_next    = '0;
            mismatch_seen_next = 1'b0;
            mode_next          = (mode == M_OPEN_WAIT) ? M_OPEN_CODE : M_CHG_CODE;
          end
        end
        M_OPEN_CODE, M_CHG_CODE: begin
          mismatch_seen_next = mismatch_seen | miss_stored;
          byte_index_next    = byte_index + 1'b1;
          if (code_last) begin
            byte_index_next    = '0;
            mismatch_seen_next = 1'b0;
            ntx                = 2'd1;
            if (!(mismatch_seen | miss_stored)) begin
              trial_count_next = 3'd0;
              tx0              = MATCHED;
              tick_count_next  = 8'd0;
              mode_next        = (mode == M_OPEN_CODE) ? M_UNLOCK : M_SETUP_RDY;
            end else if (trial_inc >= trials_eff) begin
              tx0              = WARN;
              trial_count_next = 3'd0;
              tick_count_next  = 8'd0;
              mode_next        = M_ALARM;
            end else begin
              tx0              = UNMATCHED;
              trial_count_next = trial_inc;
              mode_next        = (mode == M_OPEN_CODE) ? M_OPEN_WAIT : M_CHG_WAIT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Actuator status after the item.
  assign motor_next = (mode_next == M_UNLOCK) ? MOTOR_CW :
                      (mode_next == M_LOCK)   ? MOTOR_ACW : MOTOR_STOP;
  assign buzz_next  = mode_next == M_ALARM;

  // Result items handed to the queue; an item with no reply still gives one.
  always_comb begin
    push.count               = accept ? ((ntx == 2'd0) ? 2'd1 : ntx) : 2'd0;
    push.first.tx_valid      = ntx != 2'd0;
    push.first.tx_byte       = tx0;
    push.first.motor_dir     = motor_next;
    push.first.alarm_active  = buzz_next;
    push.first.last          = ntx != 2'd2;
    push.second.tx_valid     = 1'b1;
    push.second.tx_byte      = tx1;
    push.second.motor_dir    = motor_next;
    push.second.alarm_active = buzz_next;
    push.second.last         = 1'b1;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_BOOT;
      byte_index    <= '0;
      mismatch_seen <= 1'b0;
      trial_count   <= 3'd0;
      tick_count    <= 8'd0;
    end else if (accept) begin
      mode          <= mode_next;
      byte_index    <= byte_index_next;
      mismatch_seen <= mismatch_seen_next;
      trial_count   <= trial_count_next;
      tick_count    <= tick_count_next;
    end
  end

  // Code stores; they are written before they are ever compared.
  always_ff @(posedge clk) begin
    if (accept && !func && wr_first) begin
      first_entry[byte_index] <= rx_byte;
    end
    if (accept && !func && copy_code) begin
      stored_code <= first_entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pdlc_res_fifo.sv */
// ----------------------------------------------------------------------------
// Lock controller result queue
// Small queue that takes one or two result items per cycle and gives one per pop.
// ----------------------------------------------------------------------------
`default_nettype none

`include "password_door_lock_controller_assert.svh"

module pdlc_res_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pdlc_pkg::pdlc_push_t   push,
  input  wire logic                   pop,
  output pdlc_pkg::pdlc_result_t      head,
  output logic                        not_empty,
  output logic                        room
);
  import pdlc_pkg::*;

  pdlc_result_t      entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QPTR_W-1:0] wr_ptr_inc;

  assign wr_ptr_inc = wr_ptr + 1'b1;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_inc] <= push.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = count != '0;
  assign room      = count <= QCNT_W'(QDEPTH - 2);

  `PDLC_ASSERT(a_count_bound, count <= QCNT_W'(QDEPTH), "result queue count overflow")
  `PDLC_ASSERT_NEVER(a_push_full, (push.count != 2'd0) && !room, "push into a full queue")
  `PDLC_ASSERT(a_count_track, 1'b1 |=> count == $past(count) + QCNT_W'($past(push.count)) - QCNT_W'($past(pop)), "queue count bookkeeping off")
  `PDLC_ASSERT(a_silent_last, (not_empty && !head.tx_valid) |-> head.last, "reply-less result not marked last")

endmodule

`default_nettype wire

/* rtl/core/password_door_lock_controller.sv */
// Password door lock controller.
// Input channel item_in: each item is either a byte received from the keypad
// link (func = 0, rx_byte) or one one-second timer tick (func = 1).
// Result channel result_out: each item carries an optional reply byte
// (tx_valid, tx_byte), the motor drive and buzzer state after the input, and
// last, which marks the final result of an input. Most inputs give one result;
// the byte that ends the confirming setup entry gives two.
// Throughput: one input item per cycle while the queue has room, as the
// sequencer registers update on each accepted input. A result reaches
// result_out the cycle after its input is accepted, behind queued results.
// A four-entry result queue separates the sides: input is accepted while the
// queue has room for two results, so a stalled receiver stops input only after
// the queue fills. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect at the next edge and are meant for idle periods.
// Reset (rst, synchronous) returns to waiting for the first ready byte, loads
// the default timing registers and empties the queue.
// ----------------------------------------------------------------------------
// Password door lock controller top level
// Sequencer plus result queue on valid/ready channels.
// ----------------------------------------------------------------------------
`default_nettype none

module password_door_lock_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pdlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pdlc_pkg::CFG_DATA_W-1:0]  cfg_data,
  pdlc_in_if.sink                               item_in,
  pdlc_out_if.source                            result_out
);
  import pdlc_pkg::*;

  pdlc_push_t   push;
  pdlc_result_t head;
  logic         accept, pop, not_empty, room;

  // Item handshakes.
  assign item_in.ready = room;
  assign accept        = item_in.valid && room;
  assign pop           = not_empty && result_out.ready;

  pdlc_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .func      (item_in.func),
    .rx_byte   (item_in.rx_byte),
    .push      (push)
  );

  pdlc_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  // Result channel driven from the queue head.
  assign result_out.valid        = not_empty;
  assign result_out.tx_valid     = head.tx_valid;
  assign result_out.tx_byte      = head.tx_byte;
  assign result_out.motor_dir    = head.motor_dir;
  assign result_out.alarm_active = head.alarm_active;
  assign result_out.last         = head.last;

endmodule

`default_nettype wire
